// ----- hdl/dbsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dbsm_pkg
// Shared constants, operation codes and inter-module structs for the disk
// brush importance map.
// ----------------------------------------------------------------------------
package dbsm_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_RADIUS = 128;
	localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);

	localparam logic [8:0] ONE_FX  = 9'd256;
	localparam logic [8:0] HALF_FX = 9'd128;

	localparam logic [2:0] FN_RAISE = 3'd0;
	localparam logic [2:0] FN_LOWER = 3'd1;
	localparam logic [2:0] FN_FILL  = 3'd2;
	localparam logic [2:0] FN_WRITE = 3'd3;
	localparam logic [2:0] FN_READ  = 3'd4;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [8:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic       done;
		logic [8:0] quot;
	} div_rsp_t;

endpackage

// ----- hdl/dbsm_req_if.sv -----
// ----------------------------------------------------------------------------
// dbsm_req_if
// Command channel: operation code, position and fill value.
// ----------------------------------------------------------------------------
interface dbsm_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        func;
	logic signed [9:0] pos_x;
	logic signed [9:0] pos_y;
	logic [8:0]        fill_value;

	modport source(output valid, func, pos_x, pos_y, fill_value, input ready);
	modport sink(input valid, func, pos_x, pos_y, fill_value, output ready);
endinterface

// ----- hdl/dbsm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dbsm_rsp_if
// Result channel: read value and out-of-range flag.
// ----------------------------------------------------------------------------
interface dbsm_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] read_value;
	logic       out_of_range;

	modport source(output valid, read_value, out_of_range, input ready);
	modport sink(input valid, read_value, out_of_range, output ready);
endinterface

// ----- hdl/dbsm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dbsm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dbsm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [8:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/disk_brush_stamp_map.sv -----
// ----------------------------------------------------------------------------
// disk_brush_stamp_map
// Per-pixel importance map with raise/lower disk stamps, fill, entry write
// and entry read.
// Stamp: walks the (2r+1)^2 square; pixels off the disk or image are skipped,
//   pixels with 2*d2 < r2 are set directly, outer-ring ones use the divider.
// Write/read: S_ACC, then S_RDW for a read, then S_PUT; fill writes one entry per cycle.
// One item at a time; the result register frees the output side.
// Reset: a clearing pass writes 1.0 to every entry, req.ready low.
// ----------------------------------------------------------------------------
module disk_brush_stamp_map (
	input  logic clk,
	input  logic arst_n,
	dbsm_cfg_if.sink   cfg,
	dbsm_req_if.sink   req,
	dbsm_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_START, S_PIX, S_DIV, S_UPD, S_ACC, S_RDW, S_PUT
	} state_t;

	localparam int AW = dbsm_pkg::ADDR_W;

	state_t                state_q;
	logic [8:0]            width_q;
	logic [8:0]            height_q;
	logic [7:0]            radius_q;
	logic [2:0]            func_q;
	logic signed [9:0]     x_q;
	logic signed [9:0]     y_q;
	logic [8:0]            val_q;
	logic [7:0]            rad_q;
	logic [14:0]           r2_q;
	logic signed [8:0]     dx_q;
	logic signed [8:0]     dy_q;
	logic [14:0]           dx2_q;
	logic [14:0]           dy2_q;
	logic signed [18:0]    row_base_q;
	logic [AW-1:0]         addr_q;
	logic [8:0]            v_q;
	logic [AW-1:0]         sweep_q;
	logic                  sweep_rsp_q;
	logic [8:0]            res_value_q;
	logic                  res_oor_q;
	logic                  rsp_valid_q;
	logic [8:0]            rsp_value_q;
	logic                  rsp_oor_q;

	logic [8:0]            w_eff;
	logic [8:0]            h_eff;
	logic [7:0]            r_eff;
	logic [15:0]           r_sq_full;
	logic [8:0]            fv_sat;
	logic [15:0]           d2;
	logic signed [10:0]    px;
	logic signed [10:0]    py;
	logic                  in_img;
	logic                  in_disk;
	logic                  inner;
	logic signed [18:0]    pix_idx;
	logic signed [8:0]     pos_r;
	logic                  row_end;
	logic                  stamp_end;
	logic                  adv;
	logic signed [16:0]    dx2_next;
	logic signed [16:0]    dy2_next;
	logic signed [10:0]    y_top;
	logic signed [20:0]    base_prod;
	logic [16:0]           acc_prod;
	logic [AW-1:0]         acc_idx;
	logic                  acc_oor;
	logic [9:0]            raise_full;
	logic [8:0]            raise_v;
	logic [8:0]            lower_v;
	logic                  upd_we;

	dbsm_pkg::mem_req_t    mem_req;
	logic [8:0]            mem_rdata;
	dbsm_pkg::div_rsp_t    div_rsp;
	logic                  div_start;

	dbsm_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	dbsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (d2),
		.den    (r2_q),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (width_q == 9'd0) begin
			w_eff = 9'd1;
		end else if (width_q > 9'(dbsm_pkg::MAX_WIDTH)) begin
			w_eff = 9'(dbsm_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == 9'd0) begin
			h_eff = 9'd1;
		end else if (height_q > 9'(dbsm_pkg::MAX_HEIGHT)) begin
			h_eff = 9'(dbsm_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		if (radius_q == 8'd0) begin
			r_eff = 8'd1;
		end else if (radius_q > 8'(dbsm_pkg::MAX_RADIUS)) begin
			r_eff = 8'(dbsm_pkg::MAX_RADIUS);
		end else begin
			r_eff = radius_q;
		end
	end

	assign r_sq_full = {8'd0, r_eff} * {8'd0, r_eff};
	assign fv_sat    = (req.fill_value > dbsm_pkg::ONE_FX) ? dbsm_pkg::ONE_FX : req.fill_value;

	// stamp pixel
	assign d2      = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign px      = {x_q[9], x_q} + {{2{dx_q[8]}}, dx_q};
	assign py      = {y_q[9], y_q} + {{2{dy_q[8]}}, dy_q};
	assign in_img  = !px[10] && (px < $signed({2'b00, w_eff}))
		&& !py[10] && (py < $signed({2'b00, h_eff}));
	assign in_disk = d2 <= {1'b0, r2_q};
	assign inner   = {d2, 1'b0} < {2'b00, r2_q};
	assign pix_idx = row_base_q + {{8{px[10]}}, px};

	assign pos_r     = $signed({1'b0, rad_q});
	assign row_end   = dx_q == pos_r;
	assign stamp_end = row_end && (dy_q == pos_r);
	assign adv       = ((state_q == S_PIX) && !(in_disk && in_img)) || (state_q == S_UPD);
	assign dx2_next  = $signed({2'b00, dx2_q}) + $signed({{7{dx_q[8]}}, dx_q, 1'b1});
	assign dy2_next  = $signed({2'b00, dy2_q}) + $signed({{7{dy_q[8]}}, dy_q, 1'b1});

	assign y_top     = {y_q[9], y_q} - $signed({3'b000, rad_q});
	assign base_prod = y_top * $signed({1'b0, w_eff});

	// single entry
	assign acc_prod = {9'd0, y_q[7:0]} * {8'd0, w_eff};
	assign acc_idx  = acc_prod[AW-1:0] + {8'd0, x_q[7:0]};
	assign acc_oor  = x_q[9] || (x_q[8:0] >= w_eff) || y_q[9] || (y_q[8:0] >= h_eff);

	assign raise_full = 10'd384 - {1'b0, div_rsp.quot};
	assign raise_v    = raise_full[8:0];
	assign lower_v    = div_rsp.quot - dbsm_pkg::HALF_FX;

	assign upd_we    = (func_q == dbsm_pkg::FN_RAISE) ? (v_q > mem_rdata) : (v_q < mem_rdata);
	assign div_start = (state_q == S_PIX) && in_disk && in_img && !inner;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_SWEEP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = sweep_q;
				mem_req.wdata = val_q;
			end
			S_PIX: begin
				mem_req.re    = in_disk && in_img;
				mem_req.raddr = pix_idx[AW-1:0];
			end
			S_UPD: begin
				mem_req.we    = upd_we;
				mem_req.waddr = addr_q;
				mem_req.wdata = v_q;
			end
			S_ACC: begin
				mem_req.we    = !acc_oor && (func_q == dbsm_pkg::FN_WRITE);
				mem_req.re    = !acc_oor && (func_q == dbsm_pkg::FN_READ);
				mem_req.waddr = acc_idx;
				mem_req.raddr = acc_idx;
				mem_req.wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	assign cfg.ready = 1'b1;
	assign req.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			radius_q <= 8'd32;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dbsm_pkg::REG_WIDTH:  width_q  <= cfg.data;
				dbsm_pkg::REG_HEIGHT: height_q <= cfg.data;
				dbsm_pkg::REG_RADIUS: radius_q <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			sweep_rsp_q <= 1'b0;
			val_q       <= dbsm_pkg::ONE_FX;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != S_PUT)) begin
				rsp_valid_q <= 1'b0;
			end
			if (adv && !stamp_end) begin
				if (row_end) begin
					dx_q       <= -pos_r;
					dx2_q      <= r2_q;
					dy_q       <= dy_q + 9'sd1;
					dy2_q      <= dy2_next[14:0];
					row_base_q <= row_base_q + $signed({10'd0, w_eff});
				end else begin
					dx_q  <= dx_q + 9'sd1;
					dx2_q <= dx2_next[14:0];
				end
			end
			unique case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == '1) begin
						state_q <= sweep_rsp_q ? S_PUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						func_q      <= req.func;
						x_q         <= req.pos_x;
						y_q         <= req.pos_y;
						val_q       <= fv_sat;
						res_value_q <= '0;
						res_oor_q   <= 1'b0;
						unique case (req.func) inside
							dbsm_pkg::FN_RAISE, dbsm_pkg::FN_LOWER: begin
								rad_q   <= r_eff;
								r2_q    <= r_sq_full[14:0];
								dx2_q   <= r_sq_full[14:0];
								dy2_q   <= r_sq_full[14:0];
								dx_q    <= -$signed({1'b0, r_eff});
								dy_q    <= -$signed({1'b0, r_eff});
								state_q <= S_START;
							end
							dbsm_pkg::FN_FILL: begin
								sweep_q     <= '0;
								sweep_rsp_q <= 1'b1;
								state_q     <= S_SWEEP;
							end
							dbsm_pkg::FN_WRITE, dbsm_pkg::FN_READ: begin
								state_q <= S_ACC;
							end
							default: begin
								state_q <= S_PUT;
							end
						endcase
					end
				end
				S_START: begin
					row_base_q <= base_prod[18:0];
					state_q    <= S_PIX;
				end
				S_PIX: begin
					if (in_disk && in_img) begin
						addr_q <= pix_idx[AW-1:0];
						if (inner) begin
							v_q     <= (func_q == dbsm_pkg::FN_RAISE) ? dbsm_pkg::ONE_FX : 9'd0;
							state_q <= S_UPD;
						end else begin
							state_q <= S_DIV;
						end
					end else if (stamp_end) begin
						state_q <= S_PUT;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						v_q     <= (func_q == dbsm_pkg::FN_RAISE) ? raise_v : lower_v;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					state_q <= stamp_end ? S_PUT : S_PIX;
				end
				S_ACC: begin
					res_oor_q <= acc_oor;
					state_q   <= (!acc_oor && (func_q == dbsm_pkg::FN_READ)) ? S_RDW : S_PUT;
				end
				S_RDW: begin
					res_value_q <= mem_rdata;
					state_q     <= S_PUT;
				end
				S_PUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_value_q <= res_value_q;
						rsp_oor_q   <= res_oor_q;
						sweep_rsp_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_value   = rsp_value_q;
	assign rsp.out_of_range = rsp_oor_q;

`ifndef SYNTHESIS
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_req.we)
		else $error("store written while idle");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	a_put_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT && rsp_valid_q && !rsp.ready) |=> (state_q == S_PUT))
		else $error("result overwrote an untaken transfer");

	a_raise_only_up: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && mem_req.we && func_q == dbsm_pkg::FN_RAISE)
		|-> (v_q > mem_rdata))
		else $error("raise stamp lowered an entry");
`endif

endmodule

// ----- hdl/dbsm_div.sv -----
// ----------------------------------------------------------------------------
// dbsm_div
// Restoring divider, one quotient bit per cycle: floor(256 * num / den) for
// num <= den, nine steps per division.
// ----------------------------------------------------------------------------
module dbsm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         num,
	input  logic [14:0]         den,
	output dbsm_pkg::div_rsp_t  rsp
);

	logic [23:0] rem_q;
	logic [23:0] den_q;
	logic [8:0]  quot_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] diff;
	logic        take;

	assign diff = {1'b0, rem_q} - {1'b0, den_q};
	assign take = !diff[24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd8;
			end else if (busy_q) begin
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {num, 8'd0};
			den_q  <= {1'b0, den, 8'd0};
			quot_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				rem_q <= diff[23:0];
			end
			den_q  <= {1'b0, den_q[23:1]};
			quot_q <= {quot_q[7:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- hdl/dbsm_mem.sv -----
// ----------------------------------------------------------------------------
// dbsm_mem
// Importance store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dbsm_mem (
	input  logic                clk,
	input  dbsm_pkg::mem_req_t  req,
	output logic [8:0]          rdata
);

	logic [8:0] mem_q [dbsm_pkg::MEM_DEPTH];
	logic [8:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
